// File: src/sppc_pkg.sv
// Shared types and constants for the square-root profile position controller.
package sppc_pkg;

    // Position field width in encoder counts
    localparam int POSITION_WIDTH = 24;

    // Fixed register formats
    localparam int GAIN_FRAC     = 12;
    localparam int OUT_GAIN_FRAC = 8;
    localparam int CFG_DATA_W    = 24;
    localparam int CFG_INDEX_W   = 3;

    // Square root unit: 24-bit operands in the root zone, 48-bit radicand
    localparam int SQRT_ROOT_W = 24;
    localparam int SQRT_X_W    = 2 * SQRT_ROOT_W;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_ERROR_GAIN      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEADBAND        = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOW_ZONE_LIMIT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_SPEED       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TWICE_ACCEL     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_GAIN     = 3'd5;

    // Register reset values
    localparam logic [15:0] RST_ERROR_GAIN      = 16'd512;
    localparam logic [15:0] RST_DEADBAND        = 16'd26;
    localparam logic [23:0] RST_SLOW_ZONE_LIMIT = 24'd12800;
    localparam logic [23:0] RST_MAX_SPEED       = 24'd25600;
    localparam logic [23:0] RST_TWICE_ACCEL     = 24'd51200;
    localparam logic [15:0] RST_OUTPUT_GAIN     = 16'd5120;

    // Zone codes
    localparam logic [1:0] ZONE_DEAD = 2'd0;
    localparam logic [1:0] ZONE_ROOT = 2'd1;
    localparam logic [1:0] ZONE_FULL = 2'd2;

    // Input item
    typedef struct packed {
        logic signed [POSITION_WIDTH-1:0] target_position;
        logic signed [POSITION_WIDTH-1:0] current_position;
    } t_sppc_in;

    // Result item
    typedef struct packed {
        logic signed [15:0] velocity_command;
        logic [1:0]         zone;
    } t_sppc_out;

    // Sideband carried alongside the square root pipeline
    typedef struct packed {
        logic       neg;
        logic [1:0] zone;
    } t_sppc_side;

endpackage

// File: src/sppc_sqrt_pipe.sv
// Pipelined integer square root: one result bit per register stage.
module sppc_sqrt_pipe (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_vld,
    input  logic [sppc_pkg::SQRT_X_W-1:0]       i_x,
    input  sppc_pkg::t_sppc_side                i_side,
    output logic                                o_vld,
    output logic [sppc_pkg::SQRT_ROOT_W-1:0]    o_root,
    output sppc_pkg::t_sppc_side                o_side
);
    import sppc_pkg::*;

    localparam int ROOT_W = SQRT_ROOT_W;
    localparam int X_W    = SQRT_X_W;
    localparam int REM_W  = ROOT_W + 2;

    // Stage output registers; the last stage keeps no remainder or radicand
    logic [REM_W-1:0]  r_rem  [0:ROOT_W-2];
    logic [X_W-1:0]    r_x    [0:ROOT_W-2];
    logic [ROOT_W-1:0] r_root [0:ROOT_W-1];
    t_sppc_side        r_side [0:ROOT_W-1];
    logic              r_vld  [0:ROOT_W-1];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [X_W-1:0]    x_in;
        t_sppc_side        side_in;
        logic              vld_in;
        logic [REM_W+1:0]  rem_sh;
        logic [REM_W+1:0]  trial;
        logic [REM_W+1:0]  diff;
        logic              take;
        logic [ROOT_W-1:0] n_root;

        // Stage inputs
        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = i_x;
            assign side_in = i_side;
            assign vld_in  = i_vld;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign x_in    = r_x[k-1];
            assign side_in = r_side[k-1];
            assign vld_in  = r_vld[k-1];
        end

        // Bring down two radicand bits, try root*4+1
        assign rem_sh = {rem_in, x_in[X_W-1 -: 2]};
        assign trial  = {2'b00, root_in, 2'b01};
        assign diff   = rem_sh - trial;
        assign take   = (rem_sh >= trial);
        assign n_root = {root_in[ROOT_W-2:0], take};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_root[k] <= n_root;
            r_side[k] <= side_in;
        end

        if (k < ROOT_W - 1) begin : g_carry
            logic [REM_W-1:0] n_rem;
            assign n_rem = take ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
            always_ff @(posedge i_clk) begin
                r_rem[k] <= n_rem;
                r_x[k]   <= {x_in[X_W-3:0], 2'b00};
            end
        end
    end

    assign o_vld  = r_vld[ROOT_W-1];
    assign o_root = r_root[ROOT_W-1];
    assign o_side = r_side[ROOT_W-1];

endmodule

// File: src/sqrt_profile_position_controller.sv
// Top level of the square-root profile position controller.
//
// Command channel: an item (target and current position) is taken at a rising
// edge where start is high and busy is low. busy never rises: the datapath is
// a fixed pipeline with no stalls, so a new item may follow every cycle.
// Result channel: o_done is high for one cycle with o_result; the receiver
// must take it then, as results cannot be held off.
// Throughput: one item per cycle. The pipeline runs through the error, gain,
// scaling, zone and radicand stages, the square root unit (24 stages, one root
// bit each), and the output gain and rounding stages.
// Configuration: i_cfg_we writes register i_cfg_index; indexes beyond the list
// are ignored. The user must change registers only while no item is in flight;
// the block itself does not enforce it. Reset clears the pipeline valid bits
// and loads register defaults.
module sqrt_profile_position_controller #(
    parameter int FRACTION_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  sppc_pkg::t_sppc_in                  i_cmd,
    output logic                                o_done,
    output sppc_pkg::t_sppc_out                 o_result,
    input  logic                                i_cfg_we,
    input  logic [sppc_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [sppc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import sppc_pkg::*;

    localparam int P      = POSITION_WIDTH;
    localparam int MAG_W  = P + 1;
    localparam int PROD_W = MAG_W + 16;
    localparam int UP_SH  = (FRACTION_BITS > GAIN_FRAC) ? FRACTION_BITS - GAIN_FRAC : 0;
    localparam int DN_SH  = (FRACTION_BITS < GAIN_FRAC) ? GAIN_FRAC - FRACTION_BITS : 0;
    localparam int M_W    = PROD_W + 1 + UP_SH;
    localparam int P_W    = SQRT_ROOT_W + 16;
    localparam int OUT_SH = FRACTION_BITS + OUT_GAIN_FRAC;

    // Configuration registers
    logic [15:0] r_error_gain;
    logic [15:0] r_deadband;
    logic [23:0] r_slow_zone_limit;
    logic [23:0] r_max_speed;
    logic [23:0] r_twice_accel;
    logic [15:0] r_output_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_gain      <= RST_ERROR_GAIN;
            r_deadband        <= RST_DEADBAND;
            r_slow_zone_limit <= RST_SLOW_ZONE_LIMIT;
            r_max_speed       <= RST_MAX_SPEED;
            r_twice_accel     <= RST_TWICE_ACCEL;
            r_output_gain     <= RST_OUTPUT_GAIN;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ERROR_GAIN:      r_error_gain      <= i_cfg_wdata[15:0];
                CFG_DEADBAND:        r_deadband        <= i_cfg_wdata[15:0];
                CFG_SLOW_ZONE_LIMIT: r_slow_zone_limit <= i_cfg_wdata;
                CFG_MAX_SPEED:       r_max_speed       <= i_cfg_wdata;
                CFG_TWICE_ACCEL:     r_twice_accel     <= i_cfg_wdata;
                CFG_OUTPUT_GAIN:     r_output_gain     <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // No back-pressure anywhere in the pipeline
    assign busy = 1'b0;

    // Valid bits
    logic r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld;
    logic sq_vld;

    // Stage 1: signed error, split into sign and magnitude
    logic [MAG_W-1:0] n_diff;
    logic [MAG_W-1:0] r1_mag;
    logic             r1_neg;

    assign n_diff = {i_cmd.target_position[P-1], i_cmd.target_position}
                  - {i_cmd.current_position[P-1], i_cmd.current_position};

    always_ff @(posedge i_clk) begin
        r1_neg <= n_diff[MAG_W-1];
        r1_mag <= n_diff[MAG_W-1] ? (~n_diff + MAG_W'(1)) : n_diff;
    end

    // Stage 2: error times gain
    logic [PROD_W-1:0] r2_prod;
    logic              r2_neg;

    always_ff @(posedge i_clk) begin
        r2_prod <= PROD_W'(r1_mag) * PROD_W'(r_error_gain);
        r2_neg  <= r1_neg;
    end

    // Stage 3: rescale Q.12 to Q.F, right shifts round half up
    logic [M_W-1:0] n_m;
    logic [M_W-1:0] r3_m;
    logic           r3_neg;

    if (FRACTION_BITS > GAIN_FRAC) begin : g_scale_up
        assign n_m = M_W'(r2_prod) << UP_SH;
    end else if (FRACTION_BITS == GAIN_FRAC) begin : g_scale_same
        assign n_m = M_W'(r2_prod);
    end else begin : g_scale_down
        localparam logic [M_W-1:0] HALF = M_W'(1) << (DN_SH - 1);
        assign n_m = (M_W'(r2_prod) + HALF) >> DN_SH;
    end

    always_ff @(posedge i_clk) begin
        r3_m   <= n_m;
        r3_neg <= r2_neg;
    end

    // Stage 4: zone decision
    logic [1:0]  n_zone;
    logic [23:0] r4_m;
    t_sppc_side  r4_side;

    always_comb begin
        if (r3_m == '0 || r3_m < M_W'(r_deadband)) begin
            n_zone = ZONE_DEAD;
        end else if (r3_m > M_W'(r_slow_zone_limit)) begin
            n_zone = ZONE_FULL;
        end else begin
            n_zone = ZONE_ROOT;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_m         <= r3_m[23:0];
        r4_side.neg  <= r3_neg;
        r4_side.zone <= n_zone;
    end

    // Stage 5: radicand twice_accel * m (Q.2F)
    logic [SQRT_X_W-1:0] r5_x;
    t_sppc_side          r5_side;

    always_ff @(posedge i_clk) begin
        r5_x    <= SQRT_X_W'(r4_m) * SQRT_X_W'(r_twice_accel);
        r5_side <= r4_side;
    end

    // Square root stages
    logic [SQRT_ROOT_W-1:0] sq_root;
    t_sppc_side             sq_side;

    sppc_sqrt_pipe u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r5_vld),
        .i_x     (r5_x),
        .i_side  (r5_side),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // Stage 6: speed times output gain
    logic [SQRT_ROOT_W-1:0] n_speed;
    logic [P_W-1:0]         r6_p;
    t_sppc_side             r6_side;

    assign n_speed = (sq_side.zone == ZONE_FULL) ? r_max_speed : sq_root;

    always_ff @(posedge i_clk) begin
        r6_p    <= P_W'(n_speed) * P_W'(r_output_gain);
        r6_side <= sq_side;
    end

    // Stage 7: round, saturate, apply sign
    localparam logic [P_W:0] OUT_HALF = (P_W+1)'(1) << (OUT_SH - 1);
    localparam logic [P_W:0] POS_MAX  = (P_W+1)'(32767);
    localparam logic [P_W:0] NEG_MAX  = (P_W+1)'(32768);

    logic [P_W:0]  n_round;
    logic [15:0]   n_mag;
    t_sppc_out     n_result;

    assign n_round = ({1'b0, r6_p} + OUT_HALF) >> OUT_SH;

    always_comb begin
        if (r6_side.neg) begin
            n_mag = (n_round > NEG_MAX) ? 16'h8000 : n_round[15:0];
        end else begin
            n_mag = (n_round > POS_MAX) ? 16'h7FFF : n_round[15:0];
        end
        n_result.zone = r6_side.zone;
        if (r6_side.zone == ZONE_DEAD) begin
            n_result.velocity_command = '0;
        end else if (r6_side.neg) begin
            n_result.velocity_command = ~n_mag + 16'd1;
        end else begin
            n_result.velocity_command = n_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        o_result <= n_result;
    end

    // Valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            o_done <= 1'b0;
        end else begin
            r1_vld <= start & ~busy;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
            r6_vld <= sq_vld;
            o_done <= r6_vld;
        end
    end

endmodule
